>>> hdl/cvar_pkg.sv
// Shared types, operation codes and helpers for the checked vector arithmetic block.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package cvar_pkg;

  localparam int WORD_W = 64;
  localparam int HALF_W = WORD_W / 2;
  localparam int PROD_W = 2 * WORD_W;

  // Operation codes carried in the func field
  localparam logic [2:0] FUNC_ADD  = 3'd0;
  localparam logic [2:0] FUNC_SUB  = 3'd1;
  localparam logic [2:0] FUNC_MUL  = 3'd2;
  localparam logic [2:0] FUNC_SUM  = 3'd3;
  localparam logic [2:0] FUNC_PROD = 3'd4;

  // Scalar side register codes; the unused code behaves as SIDE_BOTH
  localparam logic [1:0] SIDE_BOTH  = 2'd0;
  localparam logic [1:0] SIDE_LEFT  = 2'd1;
  localparam logic [1:0] SIDE_RIGHT = 2'd2;

  typedef struct packed {
    logic [2:0]               func;
    logic signed [WORD_W-1:0] left_operand;
    logic signed [WORD_W-1:0] right_operand;
    logic                     end_of_vector;
  } item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     overflow;
    logic                     final_result;
  } result_t;

  // Operand stage: operands already resolved against the held scalar
  typedef struct packed {
    logic [2:0]        func;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic              eov;
    logic              first;
  } opnd_t;

  // Partial product stage
  typedef struct packed {
    logic [2:0]        func;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic              eov;
    logic              first;
    logic              b_zero;
    logic              neg;
    logic [WORD_W-1:0] pp00;
    logic [WORD_W-1:0] pp01;
    logic [WORD_W-1:0] pp10;
    logic [WORD_W-1:0] pp11;
  } pprod_t;

  // Accumulator view handed back from the execute stage
  typedef struct packed {
    logic [WORD_W-1:0] acc;
    logic              acc_busy;
  } acc_status_t;

  // Sign-extend the low dw bits of x to a full word
  function automatic logic [WORD_W-1:0] sign_ext(input logic [WORD_W-1:0] x,
                                                 input int unsigned dw);
    logic [WORD_W-1:0] top;
    logic [WORD_W-1:0] mask;
    top  = {{(WORD_W-1){1'b0}}, 1'b1} << (dw - 1);
    mask = (top << 1) - {{(WORD_W-1){1'b0}}, 1'b1};
    return ((x & mask) ^ top) - top;
  endfunction

endpackage

`default_nettype wire

>>> hdl/cvar_front.sv
// Input stage: accepts transactions, captures the held scalar and the config register,
// and loads the operand register. Depends on cvar_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cvar_front #(
  parameter int DATA_WIDTH = 64
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 item_valid,
  output logic                item_ready,
  input  cvar_pkg::item_t     item,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [1:0]           cfg_data,
  input  wire                 opnd_take,
  output logic                opnd_valid,
  output cvar_pkg::opnd_t     opnd
);
  import cvar_pkg::*;

  logic [1:0]        scalar_side;
  logic              first_pending;
  logic [WORD_W-1:0] held_scalar;
  logic [WORD_W-1:0] l;
  logic [WORD_W-1:0] r;
  logic [WORD_W-1:0] a;
  logic [WORD_W-1:0] b;
  logic              keep;
  logic              accept;

  assign item_ready = !opnd_valid || opnd_take;
  assign cfg_ready  = 1'b1;
  assign accept     = item_valid && item_ready;

  always_comb begin
    l    = sign_ext(item.left_operand, DATA_WIDTH);
    r    = sign_ext(item.right_operand, DATA_WIDTH);
    keep = (item.func <= FUNC_PROD);
    a    = l;
    b    = r;
    if (item.func <= FUNC_MUL && !first_pending) begin
      if (scalar_side == SIDE_LEFT) begin
        a = held_scalar;
      end
      if (scalar_side == SIDE_RIGHT) begin
        b = held_scalar;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scalar_side   <= SIDE_BOTH;
      first_pending <= 1'b1;
      held_scalar   <= '0;
      opnd_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        scalar_side <= cfg_data;
      end
      if (accept && keep) begin
        first_pending <= item.end_of_vector;
        if (first_pending && scalar_side == SIDE_LEFT) begin
          held_scalar <= l;
        end else if (first_pending && scalar_side == SIDE_RIGHT) begin
          held_scalar <= r;
        end
        opnd_valid <= 1'b1;
      end else if (opnd_take) begin
        opnd_valid <= 1'b0;
      end
    end
  end

  // Unknown funcs are dropped here: accepted, no state change
  always_ff @(posedge clk) begin
    if (accept && keep) begin
      opnd <= '{func: item.func, a: a, b: b, eov: item.end_of_vector,
                first: first_pending};
    end
  end

endmodule

`default_nettype wire

>>> hdl/cvar_pprod.sv
// Partial product stage: takes operand magnitudes and forms four half-word products.
// Depends on cvar_pkg; reads the accumulator from cvar_exec for product reductions.
`timescale 1ns / 1ps
`default_nettype none

module cvar_pprod (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   opnd_valid,
  input  cvar_pkg::opnd_t       opnd,
  output logic                  opnd_take,
  input  cvar_pkg::acc_status_t acc_status,
  input  wire                   pp_take,
  output logic                  pp_valid,
  output cvar_pkg::pprod_t      pp
);
  import cvar_pkg::*;

  logic              hazard;
  logic [WORD_W-1:0] ma;
  logic [WORD_W-1:0] mb;
  logic [WORD_W-1:0] ua;
  logic [WORD_W-1:0] ub;
  logic              na;
  logic              nb;

  // A chained product must see the accumulator after the reduction ahead of it
  assign hazard    = opnd.func == FUNC_PROD && !opnd.first && acc_status.acc_busy;
  assign opnd_take = opnd_valid && (!pp_valid || pp_take) && !hazard;

  always_comb begin
    if (opnd.func == FUNC_PROD) begin
      ma = opnd.first ? {{(WORD_W-1){1'b0}}, 1'b1} : acc_status.acc;
    end else begin
      ma = opnd.a;
    end
    mb = opnd.b;
    na = ma[WORD_W-1];
    nb = mb[WORD_W-1];
    ua = na ? (~ma + {{(WORD_W-1){1'b0}}, 1'b1}) : ma;
    ub = nb ? (~mb + {{(WORD_W-1){1'b0}}, 1'b1}) : mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_valid <= 1'b0;
    end else if (opnd_take) begin
      pp_valid <= 1'b1;
    end else if (pp_take) begin
      pp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (opnd_take) begin
      pp.func   <= opnd.func;
      pp.a      <= opnd.a;
      pp.b      <= opnd.b;
      pp.eov    <= opnd.eov;
      pp.first  <= opnd.first;
      pp.b_zero <= (mb == '0);
      pp.neg    <= na ^ nb;
      pp.pp00   <= {{HALF_W{1'b0}}, ua[HALF_W-1:0]} * {{HALF_W{1'b0}}, ub[HALF_W-1:0]};
      pp.pp01   <= {{HALF_W{1'b0}}, ua[HALF_W-1:0]} * {{HALF_W{1'b0}}, ub[WORD_W-1:HALF_W]};
      pp.pp10   <= {{HALF_W{1'b0}}, ua[WORD_W-1:HALF_W]} * {{HALF_W{1'b0}}, ub[HALF_W-1:0]};
      pp.pp11   <= {{HALF_W{1'b0}}, ua[WORD_W-1:HALF_W]}
                 * {{HALF_W{1'b0}}, ub[WORD_W-1:HALF_W]};
    end
  end

endmodule

`default_nettype wire

>>> hdl/cvar_exec.sv
// Execute stage: finishes add, subtract and multiply with overflow checks, keeps the
// reduction state and drives the result register. Depends on cvar_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cvar_exec #(
  parameter int DATA_WIDTH = 64
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   pp_valid,
  input  cvar_pkg::pprod_t      pp,
  output logic                  pp_take,
  output cvar_pkg::acc_status_t acc_status,
  output logic                  result_valid,
  input  wire                   result_ready,
  output cvar_pkg::result_t     result
);
  import cvar_pkg::*;

  logic [WORD_W-1:0] acc;
  logic              zero_seen;
  logic              error_sticky;

  logic [PROD_W-1:0] mag;
  logic [PROD_W-1:0] prod;
  logic [WORD_W-1:0] ms;
  logic              movf;
  logic [WORD_W-1:0] add_x;
  logic [WORD_W-1:0] add_r;
  logic [WORD_W-1:0] add_s;
  logic              aovf;
  logic [WORD_W-1:0] sub_r;
  logic [WORD_W-1:0] sub_s;
  logic              sovf;
  logic              err_in;
  logic              zero_in;
  logic              zero;
  logic              ovf;
  logic              emit;
  logic [WORD_W-1:0] val;
  logic [WORD_W-1:0] acc_next;

  always_comb begin
    mag  = {{WORD_W{1'b0}}, pp.pp00}
         + {{HALF_W{1'b0}}, pp.pp01, {HALF_W{1'b0}}}
         + {{HALF_W{1'b0}}, pp.pp10, {HALF_W{1'b0}}}
         + {pp.pp11, {WORD_W{1'b0}}};
    prod = pp.neg ? (~mag + {{(PROD_W-1){1'b0}}, 1'b1}) : mag;
    ms   = sign_ext(prod[WORD_W-1:0], DATA_WIDTH);
    movf = (ms != prod[WORD_W-1:0]) || (prod[PROD_W-1:WORD_W] != {WORD_W{ms[WORD_W-1]}});

    // One adder serves element add and the running sum
    if (pp.func == FUNC_SUM) begin
      add_x = pp.first ? '0 : acc;
    end else begin
      add_x = pp.a;
    end
    add_r = add_x + pp.b;
    add_s = sign_ext(add_r, DATA_WIDTH);
    aovf  = (((add_x ^ add_r) & (pp.b ^ add_r)) >> (WORD_W - 1)) != '0 || add_s != add_r;

    sub_r = pp.a - pp.b;
    sub_s = sign_ext(sub_r, DATA_WIDTH);
    sovf  = (((pp.a ^ pp.b) & (pp.a ^ sub_r)) >> (WORD_W - 1)) != '0 || sub_s != sub_r;

    err_in   = pp.first ? 1'b0 : error_sticky;
    zero_in  = pp.first ? 1'b0 : zero_seen;
    zero     = zero_in;
    ovf      = 1'b0;
    emit     = 1'b0;
    val      = '0;
    acc_next = acc;

    unique case (pp.func)
      FUNC_ADD: begin
        val  = add_s;
        ovf  = aovf;
        emit = 1'b1;
      end
      FUNC_SUB: begin
        val  = sub_s;
        ovf  = sovf;
        emit = 1'b1;
      end
      FUNC_MUL: begin
        val  = ms;
        ovf  = movf;
        emit = 1'b1;
      end
      FUNC_SUM: begin
        acc_next = add_s;
        val      = add_s;
        ovf      = aovf;
        emit     = pp.eov;
      end
      FUNC_PROD: begin
        // After a zero element the total stays zero and is no longer checked
        if (!zero_in) begin
          if (pp.b_zero) begin
            zero = 1'b1;
          end else begin
            ovf      = movf;
            acc_next = ms;
          end
        end
        val  = zero ? '0 : acc_next;
        emit = pp.eov;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign pp_take    = pp_valid && (!emit || !result_valid || result_ready);
  assign acc_status = '{acc: acc,
                        acc_busy: pp_valid && (pp.func == FUNC_SUM || pp.func == FUNC_PROD)};

  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      zero_seen    <= 1'b0;
      error_sticky <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (pp_take) begin
        if (pp.eov) begin
          acc          <= '0;
          zero_seen    <= 1'b0;
          error_sticky <= 1'b0;
        end else begin
          acc          <= acc_next;
          zero_seen    <= zero;
          error_sticky <= err_in || ovf;
        end
      end
      if (pp_take && emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pp_take && emit) begin
      result <= '{value: val, overflow: err_in || ovf, final_result: pp.eov};
    end
  end

endmodule

`default_nettype wire

>>> hdl/checked_vector_arith_reduce.sv
// Top level of the checked vector arithmetic block: operand, partial product and
// execute stages. Depends on cvar_pkg, cvar_front, cvar_pprod and cvar_exec.
//
// Usage:
//   item channel   - one vector element per transaction (func, operands, end_of_vector).
//   result channel - one transaction per element-wise op, one per reduction at the
//                    element that ends the vector. Unknown funcs are taken and dropped.
//   cfg channel    - writes scalar_side; always ready. Write it only between transactions.
// An item passes through the operand, partial product and result registers in turn.
// One item per clock while no stage stalls. A product reduction element that follows
//   another reduction element of the same vector waits while that element sits in the
//   execute stage, since its partial products need the accumulator it is still producing.
// Reset: the pipeline empties, reduction state clears, scalar_side returns to both
//   vectors and the next item starts a new vector.
// Stall: while result_ready is low the result holds; the stages behind it keep filling
//   and item_ready drops once all three registers are occupied.
`timescale 1ns / 1ps
`default_nettype none

module checked_vector_arith_reduce #(
  parameter int DATA_WIDTH = 64
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 item_valid,
  output logic                item_ready,
  input  cvar_pkg::item_t     item,
  output logic                result_valid,
  input  wire                 result_ready,
  output cvar_pkg::result_t   result,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [1:0]           cfg_data
);
  import cvar_pkg::*;

  logic        opnd_valid;
  logic        opnd_take;
  opnd_t       opnd;
  logic        pp_valid;
  logic        pp_take;
  pprod_t      pp;
  acc_status_t acc_status;

  cvar_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .opnd_take  (opnd_take),
    .opnd_valid (opnd_valid),
    .opnd       (opnd)
  );

  cvar_pprod u_pprod (
    .clk        (clk),
    .rst        (rst),
    .opnd_valid (opnd_valid),
    .opnd       (opnd),
    .opnd_take  (opnd_take),
    .acc_status (acc_status),
    .pp_take    (pp_take),
    .pp_valid   (pp_valid),
    .pp         (pp)
  );

  cvar_exec #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_exec (
    .clk          (clk),
    .rst          (rst),
    .pp_valid     (pp_valid),
    .pp           (pp),
    .pp_take      (pp_take),
    .acc_status   (acc_status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

>>> hdl/cvar_checker.sv
// Port-level checks for checked_vector_arith_reduce, attached with a bind.
// Depends on cvar_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cvar_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 item_valid,
  input wire                 item_ready,
  input cvar_pkg::item_t     item,
  input wire                 result_valid,
  input wire                 result_ready,
  input cvar_pkg::result_t   result
);

  // Reset empties the result register
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid set right after reset");

  // Reset empties the whole pipeline, so the input side is open
  assert property (@(posedge clk) rst |=> item_ready)
    else $error("item_ready low right after reset");

  // A held result keeps its transaction
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // A waiting input transaction stays put until taken
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable(item))
    else $error("waiting item changed before it was taken");

  // With the receiver taking, a blocked input is open again in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    !item_ready && result_ready |=> item_ready)
    else $error("input stayed blocked with result_ready high");

endmodule

bind checked_vector_arith_reduce cvar_checker u_checker (.*);

`default_nettype wire

>>> sim/checked_vector_arith_reduce_tb.sv
// Self-checking testbench for checked_vector_arith_reduce: directed and random vectors
// through all operations and scalar_side settings, scored against an in-file predictor.
// Depends on cvar_pkg and the checked_vector_arith_reduce RTL.
`timescale 1ns / 1ps

module checked_vector_arith_reduce_tb;
  import cvar_pkg::*;

  localparam logic [2:0]  FUNC_FIRST_UNUSED = 3'd5;
  localparam logic [2:0]  FUNC_MID_UNUSED   = 3'd6;
  localparam logic [2:0]  FUNC_LAST_UNUSED  = 3'd7;
  localparam logic [1:0]  SIDE_SPARE        = 2'd3;
  localparam logic [63:0] WORD_MAX          = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] WORD_MIN          = 64'h8000_0000_0000_0000;
  localparam logic [63:0] WORD_ONES         = 64'hffff_ffff_ffff_ffff;
  localparam int          SETTLE_CYCLES     = 8;
  localparam int          IDLE_LIMIT        = 2000;
  localparam int          ELEMENT_TARGET    = 1350;

  logic       clk = 1'b0;
  logic       rst;
  logic       item_valid;
  logic       item_ready;
  item_t      item;
  logic       result_valid;
  logic       result_ready = 1'b0;
  result_t    result;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_data;

  // Predictor state
  logic [1:0]  scalar_mode;
  logic [63:0] running_total;
  logic        product_zeroed;
  logic        vector_overflow;
  logic [63:0] held_operand;
  logic        at_vector_start;

  result_t expected_results[$];
  result_t want;
  int      mismatches = 0;
  int      elements_sent = 0;
  int      idle_cycles = 0;
  int      stall_left = 0;
  bit      no_idle = 1'b0;

  checked_vector_arith_reduce #(.DATA_WIDTH(64)) DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  // Checked arithmetic: bit 64 is the overflow flag, bits 63:0 the wrapped value
  function automatic logic [64:0] add_with_flag(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    return {(a[63] == b[63]) && (r[63] != a[63]), r};
  endfunction

  function automatic logic [64:0] sub_with_flag(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    return {(a[63] != b[63]) && (r[63] != a[63]), r};
  endfunction

  function automatic logic [64:0] mul_with_flag(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {{64{a[63]}}, a} * {{64{b[63]}}, b};
    return {!((&p[127:63]) || !(|p[127:63])), p[63:0]};
  endfunction

  task automatic reset_predictor();
    scalar_mode     = SIDE_BOTH;
    running_total   = '0;
    product_zeroed  = 1'b0;
    vector_overflow = 1'b0;
    held_operand    = '0;
    at_vector_start = 1'b1;
  endtask

  // Advance the predictor by one accepted element; queue its result if it makes one
  task automatic predict_element(input item_t it);
    logic [63:0] l;
    logic [63:0] r;
    logic [63:0] prev;
    logic [63:0] val;
    logic [64:0] res;
    logic        first;
    logic        err;
    logic        zero;
    logic        ovf;
    logic        emit;
    result_t     out;
    l     = it.left_operand;
    r     = it.right_operand;
    first = at_vector_start;
    err   = first ? 1'b0 : vector_overflow;
    zero  = first ? 1'b0 : product_zeroed;
    ovf   = 1'b0;
    emit  = 1'b0;
    val   = '0;
    if (it.func > FUNC_PROD) return;
    if (first) begin
      if (scalar_mode == SIDE_LEFT) held_operand = l;
      else if (scalar_mode == SIDE_RIGHT) held_operand = r;
    end
    case (it.func)
      FUNC_ADD, FUNC_SUB, FUNC_MUL: begin
        if (scalar_mode == SIDE_LEFT) l = held_operand;
        else if (scalar_mode == SIDE_RIGHT) r = held_operand;
        if (it.func == FUNC_ADD) res = add_with_flag(l, r);
        else if (it.func == FUNC_SUB) res = sub_with_flag(l, r);
        else res = mul_with_flag(l, r);
        {ovf, val} = res;
        emit = 1'b1;
      end
      FUNC_SUM: begin
        prev = first ? 64'd0 : running_total;
        {ovf, running_total} = add_with_flag(prev, r);
        val  = running_total;
        emit = it.end_of_vector;
      end
      default: begin
        prev = first ? 64'd1 : running_total;
        if (!zero) begin
          if (r == '0) zero = 1'b1;
          else {ovf, running_total} = mul_with_flag(prev, r);
        end
        val  = zero ? 64'd0 : running_total;
        emit = it.end_of_vector;
      end
    endcase
    err = err || ovf;
    if (emit) begin
      out.value        = val;
      out.overflow     = err;
      out.final_result = it.end_of_vector;
      expected_results.push_back(out);
    end
    if (it.end_of_vector) begin
      at_vector_start = 1'b1;
      vector_overflow = 1'b0;
      product_zeroed  = 1'b0;
      running_total   = '0;
    end else begin
      at_vector_start = 1'b0;
      vector_overflow = err;
      product_zeroed  = zero;
    end
  endtask

  // Mostly short idles, a few long ones
  function automatic int idle_length();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return $urandom_range(1, 2);
    if (pick < 92) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand_operand();
    int          pick;
    longint      near_zero;
    logic [63:0] p;
    pick = $urandom_range(99);
    if (pick < 30) return {$urandom, $urandom};
    if (pick < 55) begin
      near_zero = longint'($urandom_range(32)) - 16;
      return near_zero;
    end
    if (pick < 70) begin
      case ($urandom_range(4))
        0: return WORD_MAX;
        1: return WORD_MIN;
        2: return '0;
        3: return 64'd1;
        default: return WORD_ONES;
      endcase
    end
    if (pick < 88) begin
      p = 64'd1 << $urandom_range(63);
      if ($urandom_range(1)) p = -p;
      return p + 64'($urandom_range(2)) - 64'd1;
    end
    p = {32'd0, $urandom};
    return p[31] ? {32'hffff_ffff, p[31:0]} : p;
  endfunction

  function automatic item_t make_item(input logic [2:0] f, input logic [63:0] l,
                                      input logic [63:0] r, input logic eov);
    item_t it;
    it.func          = f;
    it.left_operand  = l;
    it.right_operand = r;
    it.end_of_vector = eov;
    return it;
  endfunction

  // Present one element after a random gap and hold it until accepted
  task automatic send_element(input item_t it);
    int gap;
    gap = (no_idle || $urandom_range(99) < 55) ? 0 : idle_length();
    if (gap > 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    predict_element(it);
    if (it.func <= FUNC_PROD) elements_sent++;
  endtask

  // Hold off the sender until every expected result is in and the pipeline is empty
  task automatic wait_drained();
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_scalar_side(input logic [1:0] side);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= side;
    do @(posedge clk); while (!cfg_ready);
    scalar_mode = side;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_extremes();
    write_scalar_side(SIDE_BOTH);
    send_element(make_item(FUNC_ADD, WORD_MAX, 64'd1, 1'b0));
    send_element(make_item(FUNC_ADD, 64'd1, 64'd1, 1'b1));
    send_element(make_item(FUNC_ADD, WORD_MIN, WORD_ONES, 1'b1));
    send_element(make_item(FUNC_SUB, WORD_MIN, 64'd1, 1'b1));
    send_element(make_item(FUNC_SUB, 64'd0, WORD_MIN, 1'b1));
    send_element(make_item(FUNC_SUB, WORD_ONES, WORD_MAX, 1'b1));
    send_element(make_item(FUNC_MUL, WORD_MIN, WORD_ONES, 1'b1));
    send_element(make_item(FUNC_MUL, WORD_MAX, WORD_MAX, 1'b0));
    send_element(make_item(FUNC_MUL, WORD_ONES, WORD_ONES, 1'b1));
    send_element(make_item(FUNC_MUL, 64'h1_0000_0000, 64'hffff_ffff_8000_0000, 1'b1));
    send_element(make_item(FUNC_ADD, WORD_MAX, WORD_MIN, 1'b1));
    // sum wraps and keeps accumulating after the overflow
    send_element(make_item(FUNC_SUM, '0, WORD_MAX, 1'b0));
    send_element(make_item(FUNC_SUM, '0, 64'd1, 1'b0));
    send_element(make_item(FUNC_SUM, '0, -64'd5, 1'b1));
    // overflow before a zero stays flagged
    send_element(make_item(FUNC_PROD, '0, 64'h1_0000_0000, 1'b0));
    send_element(make_item(FUNC_PROD, '0, 64'h1_0000_0000, 1'b0));
    send_element(make_item(FUNC_PROD, '0, '0, 1'b0));
    send_element(make_item(FUNC_PROD, '0, WORD_MAX, 1'b1));
    // zero first masks later overflow
    send_element(make_item(FUNC_PROD, '0, '0, 1'b0));
    send_element(make_item(FUNC_PROD, '0, WORD_MIN, 1'b0));
    send_element(make_item(FUNC_PROD, '0, WORD_MIN, 1'b1));
    send_element(make_item(FUNC_PROD, WORD_ONES, 64'd7, 1'b1));
    send_element(make_item(FUNC_SUM, WORD_ONES, WORD_MIN, 1'b1));
    // unknown funcs are dropped, even when marked last
    send_element(make_item(FUNC_SUM, '0, 64'd3, 1'b0));
    send_element(make_item(FUNC_LAST_UNUSED, WORD_ONES, WORD_ONES, 1'b1));
    send_element(make_item(FUNC_FIRST_UNUSED, WORD_MAX, 64'd9, 1'b0));
    send_element(make_item(FUNC_MID_UNUSED, WORD_MIN, '0, 1'b1));
    send_element(make_item(FUNC_SUM, '0, 64'd4, 1'b1));
    // mixed funcs share the accumulator
    send_element(make_item(FUNC_SUM, '0, 64'd10, 1'b0));
    send_element(make_item(FUNC_MUL, 64'd3, 64'd4, 1'b0));
    send_element(make_item(FUNC_PROD, '0, 64'd2, 1'b1));
  endtask

  task automatic test_scalar_sides();
    write_scalar_side(SIDE_LEFT);
    send_element(make_item(FUNC_ADD, 64'd5, 64'd100, 1'b0));
    send_element(make_item(FUNC_SUB, 64'd9, 64'd3, 1'b0));
    send_element(make_item(FUNC_MUL, WORD_MAX, WORD_MAX, 1'b1));
    write_scalar_side(SIDE_RIGHT);
    send_element(make_item(FUNC_MUL, 64'd3, 64'd7, 1'b0));
    send_element(make_item(FUNC_MUL, WORD_MAX, 64'd999, 1'b1));
    // a reduction on the first element still captures the scalar
    send_element(make_item(FUNC_SUM, WORD_ONES, 64'd4, 1'b0));
    send_element(make_item(FUNC_ADD, 64'd1, 64'd100, 1'b1));
    write_scalar_side(SIDE_SPARE);
    send_element(make_item(FUNC_ADD, 64'd2, 64'd3, 1'b0));
    send_element(make_item(FUNC_SUB, 64'd4, 64'd5, 1'b1));
  endtask

  task automatic send_random_vector();
    int          len;
    int          kind;
    logic [2:0]  vec_func;
    item_t       it;
    len      = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 24);
    kind     = $urandom_range(99);
    vec_func = 3'($urandom_range(FUNC_ADD, FUNC_PROD));
    no_idle  = ($urandom_range(99) < 10);
    for (int i = 0; i < len; i++) begin
      it.func = (kind < 75) ? vec_func : 3'($urandom_range(FUNC_ADD, FUNC_PROD));
      if (kind >= 88 && i != len - 1 && $urandom_range(99) < 35)
        it.func = 3'($urandom_range(FUNC_FIRST_UNUSED, FUNC_LAST_UNUSED));
      it.left_operand  = rand_operand();
      it.right_operand = rand_operand();
      it.end_of_vector = (i == len - 1) || (it.func > FUNC_PROD && $urandom_range(1));
      send_element(it);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_vectors();
    int phase;
    int budget;
    int vectors;
    phase   = 0;
    vectors = 0;
    while (elements_sent < ELEMENT_TARGET) begin
      write_scalar_side(phase < 4 ? 2'(phase) : 2'($urandom_range(SIDE_BOTH, SIDE_SPARE)));
      budget = elements_sent + 160;
      while (elements_sent < budget && elements_sent < ELEMENT_TARGET) begin
        send_random_vector();
        vectors++;
        // let the pipeline run dry now and then
        if (vectors % 40 == 0) wait_drained();
      end
      phase++;
    end
  endtask

  // Result side ready, with random stalls
  always @(negedge clk) begin
    if (stall_left == 0 && !no_idle && $urandom_range(99) < 25) stall_left = idle_length();
    if (stall_left > 0) begin
      result_ready <= 1'b0;
      stall_left--;
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %h ovf %b final %b",
                   result.value, result.overflow, result.final_result);
      end else begin
        want = expected_results.pop_front();
        if (result.value !== want.value || result.overflow !== want.overflow ||
            result.final_result !== want.final_result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected value %h ovf %b final %b, got %h ovf %b final %b",
                     want.value, want.overflow, want.final_result,
                     result.value, result.overflow, result.final_result);
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    cfg_valid    = 1'b0;
    cfg_data     = SIDE_BOTH;
    reset_predictor();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    test_scalar_sides();
    test_random_vectors();
    wait_drained();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
